// ===== design/sma_pkg.sv =====
// ----------------------------------------------------------------------------
// sma_pkg
// Shared types and constants of the scaled moving-average ring.
// ----------------------------------------------------------------------------
package sma_pkg;

  localparam int DATA_W = 16;
  localparam int SUM_W  = 23;
  localparam int WIN_W  = 6;
  localparam int POS_W  = 6;
  localparam int SLOT_W = 6;
  localparam int CFG_AW = 2;

  localparam logic [CFG_AW-1:0] CFG_GAIN   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_OFFSET = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_WINDOW = 2'd2;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic signed [DATA_W-1:0] GAIN_RST   = 16'sd256;
  localparam logic signed [DATA_W-1:0] OFFSET_RST = 16'sd0;
  localparam logic [WIN_W-1:0]         WINDOW_RST = 6'd8;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [DATA_W-1:0]  raw;
    logic [POS_W-1:0]          pos;
    logic                      past;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  raw_value;
    logic signed [DATA_W-1:0]  filtered_value;
    logic [SLOT_W-1:0]         write_slot;
    logic                      is_full;
  } res_t;

endpackage

// ===== design/sma_ram.sv =====
// ----------------------------------------------------------------------------
// sma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/sma_fifo.sv =====
// ----------------------------------------------------------------------------
// sma_fifo
// Two-entry queue between producer and consumer.
// ----------------------------------------------------------------------------
module sma_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wptr_r;
  logic             rptr_r;
  logic [1:0]       count_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (do_wr) begin
        wptr_r <= ~wptr_r;
      end
      if (do_rd) begin
        rptr_r <= ~rptr_r;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 2'd1;
      end else if (!do_wr && do_rd) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

// ===== design/sma_front.sv =====
// ----------------------------------------------------------------------------
// sma_front
// Accepts items, classifies them and scales add samples into the command queue.
// ----------------------------------------------------------------------------
module sma_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic                                in_kind,
  input  logic signed [sma_pkg::DATA_W-1:0]   in_sample,
  input  logic [sma_pkg::POS_W-1:0]           in_position,
  input  logic                                in_look_past,
  input  logic signed [sma_pkg::DATA_W-1:0]   gain,
  input  logic signed [sma_pkg::DATA_W-1:0]   offset,
  output logic                                cmd_valid,
  output sma_pkg::cmd_t                       cmd,
  input  logic                                cmd_pop
);

  import sma_pkg::*;

  logic                   s1_valid_r;
  op_t                    s1_op_r;
  logic signed [31:0]     s1_prod_r;
  logic [POS_W-1:0]       s1_pos_r;
  logic                   s1_past_r;
  logic signed [31:0]     prod_nxt;
  op_t                    op_nxt;
  logic signed [24:0]     scaled;
  logic signed [DATA_W-1:0] raw_sat;
  logic                   q_full;
  logic                   q_empty;
  logic                   accept;
  cmd_t                   q_in;
  logic [$bits(cmd_t)-1:0] q_out;

  assign accept   = in_push & ~in_full;
  assign in_full  = s1_valid_r & q_full;
  assign prod_nxt = gain * in_sample;

  always_comb begin
    case (in_kind)
      KIND_ADD:  op_nxt = OP_ADD;
      KIND_READ: op_nxt = OP_READ;
      default:   op_nxt = OP_ADD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept | (s1_valid_r & q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r   <= op_nxt;
      s1_prod_r <= prod_nxt;
      s1_pos_r  <= in_position;
      s1_past_r <= in_look_past;
    end
  end

  assign scaled = 25'(s1_prod_r >>> 8) + 25'(offset);

  always_comb begin
    if (scaled > 25'sd32767) begin
      raw_sat = 16'sh7FFF;
    end else if (scaled < -25'sd32768) begin
      raw_sat = 16'sh8000;
    end else begin
      raw_sat = scaled[DATA_W-1:0];
    end
  end

  always_comb begin
    q_in.op   = s1_op_r;
    q_in.raw  = raw_sat;
    q_in.pos  = s1_pos_r;
    q_in.past = s1_past_r;
  end

  sma_fifo #(
    .WIDTH($bits(cmd_t))
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (s1_valid_r),
    .wr_data (q_in),
    .full    (q_full),
    .rd_en   (cmd_pop),
    .rd_data (q_out),
    .empty   (q_empty)
  );

  assign cmd_valid = ~q_empty;
  assign cmd       = cmd_t'(q_out);

endmodule

// ===== design/sma_back.sv =====
// ----------------------------------------------------------------------------
// sma_back
// Executes commands: ring update, running sum, averaging divider and reads.
// ----------------------------------------------------------------------------
module sma_back #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sma_pkg::WIN_W-1:0]     window_len,
  input  logic                          cmd_valid,
  input  sma_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  output logic                          res_push,
  output sma_pkg::res_t                 res,
  input  logic                          res_full
);

  import sma_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic signed [8:0] DEPTH_S = 9'(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
  localparam logic [4:0] DIV_LAST = 5'(SUM_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP,
    S_FETCH,
    S_LATCH,
    S_SUM,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

  state_t                   state_r;
  op_t                      op_r;
  logic signed [DATA_W-1:0] raw_r;
  logic signed [8:0]        e_r;
  logic [ADDR_W-1:0]        addr_r;
  logic [SUM_W-1:0]         sum_r;
  logic [ADDR_W-1:0]        slot_r;
  logic                     full_r;
  logic [DEPTH-1:0]         valid_r;
  logic                     vld_q_r;
  logic signed [DATA_W-1:0] drop_r;
  logic                     sign_r;
  logic [WIN_W-1:0]         rem_r;
  logic [SUM_W-1:0]         dvd_r;
  logic [4:0]               cnt_r;
  logic [WIN_W-1:0]         w_r;
  res_t                     res_r;

  logic [WIN_W-1:0]         w_eff;
  logic [SUM_W-1:0]         sum_new;
  logic [SUM_W-1:0]         mag_new;
  logic [WIN_W:0]           trial;
  logic                     q_bit;
  logic signed [DATA_W-1:0] avg_sat;
  logic [ADDR_W-1:0]        slot_inc;
  logic [ADDR_W+SLOT_W-1:0] slot_ext;
  logic [ADDR_W+SLOT_W-1:0] slot_inc_ext;
  logic [DATA_W-1:0]        s_rdata;
  logic [DATA_W-1:0]        a_rdata;
  logic                     s_we;
  logic                     a_we;
  logic                     re;
  logic                     in_range;

  assign w_eff    = (window_len == '0) ? WIN_W'(1) : window_len;
  assign sum_new  = sum_r + SUM_W'(raw_r) - SUM_W'(drop_r);
  assign mag_new  = sum_new[SUM_W-1] ? (~sum_new + SUM_W'(1)) : sum_new;
  assign trial    = {rem_r, dvd_r[SUM_W-1]};
  assign q_bit    = (trial >= {1'b0, w_r});
  assign slot_inc = (slot_r == LAST_SLOT) ? '0 : slot_r + ADDR_W'(1);
  assign slot_ext     = {{SLOT_W{1'b0}}, slot_r};
  assign slot_inc_ext = {{SLOT_W{1'b0}}, slot_inc};
  assign in_range = (e_r >= 9'sd0) && (e_r < DEPTH_S);

  always_comb begin
    if (sign_r) begin
      if (dvd_r > SUM_W'(32768)) begin
        avg_sat = 16'sh8000;
      end else begin
        avg_sat = DATA_W'(~dvd_r + SUM_W'(1));
      end
    end else begin
      if (dvd_r > SUM_W'(32767)) begin
        avg_sat = 16'sh7FFF;
      end else begin
        avg_sat = DATA_W'(dvd_r);
      end
    end
  end

  assign cmd_pop  = (state_r == S_IDLE) & cmd_valid;
  assign s_we     = cmd_pop & (cmd.op == OP_ADD);
  assign a_we     = (state_r == S_FIN);
  assign re       = (state_r == S_FETCH);
  assign res_push = (state_r == S_DONE) & ~res_full;
  assign res      = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_r   <= '0;
      slot_r  <= '0;
      full_r  <= 1'b0;
      valid_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            op_r  <= cmd.op;
            raw_r <= cmd.raw;
            w_r   <= w_eff;
            case (cmd.op)
              OP_ADD: begin
                valid_r[slot_r] <= 1'b1;
                e_r <= $signed(9'(slot_r) - 9'(w_eff));
              end
              default: begin
                if (cmd.past) begin
                  e_r <= $signed(9'(slot_r) - 9'd1 - 9'(cmd.pos));
                end else begin
                  e_r <= $signed(9'(slot_r) - 9'd1 + 9'(cmd.pos));
                end
              end
            endcase
            state_r <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (e_r < 9'sd0) begin
            e_r <= e_r + DEPTH_S;
          end else if (!in_range) begin
            e_r <= e_r - DEPTH_S;
          end else begin
            addr_r <= e_r[ADDR_W-1:0];
            if (op_r == OP_ADD && e_r[ADDR_W-1:0] == slot_r) begin
              drop_r  <= raw_r;
              state_r <= S_SUM;
            end else begin
              state_r <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          vld_q_r <= valid_r[addr_r];
          state_r <= S_LATCH;
        end
        S_LATCH: begin
          if (op_r == OP_ADD) begin
            drop_r  <= vld_q_r ? $signed(s_rdata) : '0;
            state_r <= S_SUM;
          end else begin
            res_r.raw_value      <= vld_q_r ? $signed(s_rdata) : '0;
            res_r.filtered_value <= vld_q_r ? $signed(a_rdata) : '0;
            res_r.write_slot     <= slot_ext[SLOT_W-1:0];
            res_r.is_full        <= full_r;
            state_r              <= S_DONE;
          end
        end
        S_SUM: begin
          sum_r   <= sum_new;
          sign_r  <= sum_new[SUM_W-1];
          dvd_r   <= mag_new;
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= q_bit ? WIN_W'(trial - {1'b0, w_r}) : trial[WIN_W-1:0];
          dvd_r <= {dvd_r[SUM_W-2:0], q_bit};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == DIV_LAST) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          slot_r <= slot_inc;
          if (slot_r == LAST_SLOT) begin
            full_r <= 1'b1;
          end
          res_r.raw_value      <= raw_r;
          res_r.filtered_value <= avg_sat;
          res_r.write_slot     <= slot_inc_ext[SLOT_W-1:0];
          res_r.is_full        <= full_r | (slot_r == LAST_SLOT);
          state_r              <= S_DONE;
        end
        S_DONE: begin
          if (!res_full) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  sma_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_sample_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (slot_r),
    .wdata (cmd.raw),
    .re    (re),
    .raddr (addr_r),
    .rdata (s_rdata)
  );

  sma_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_average_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (slot_r),
    .wdata (avg_sat),
    .re    (re),
    .raddr (addr_r),
    .rdata (a_rdata)
  );

endmodule

// ===== design/scaled_moving_average_ring.sv =====
// ----------------------------------------------------------------------------
// scaled_moving_average_ring
// Scaled sample ring with running-sum moving average and positional reads.
// ----------------------------------------------------------------------------
// An add item is scaled by gain (Q8.8), offset and saturated, stored in a ring
// of DEPTH entries, and the windowed average of the last window_len samples is
// stored in a second ring; a read item returns both entries at a distance from
// the newest one. Every item yields one result. Items enter a one-stage front
// and a two-entry command queue; the back end handles one item at a time. An
// add brings its drop slot into range in S_WRAP, one DEPTH wrap per step, and
// then runs the 23 steps of the restoring divider, one quotient bit per cycle;
// a read brings its position into range the same way and then reads both rings
// through the single read port of each. Results wait in a two-entry output
// queue. Both rings read as zero until written; no clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module scaled_moving_average_ring #(
  parameter int DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sma_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [sma_pkg::DATA_W-1:0]         cfg_wdata,
  input  logic                               push,
  output logic                               full,
  input  logic                               in_kind,
  input  logic signed [sma_pkg::DATA_W-1:0]  in_sample,
  input  logic [sma_pkg::POS_W-1:0]          in_position,
  input  logic                               in_look_past,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [sma_pkg::DATA_W-1:0]  out_raw_value,
  output logic signed [sma_pkg::DATA_W-1:0]  out_filtered_value,
  output logic [sma_pkg::SLOT_W-1:0]         out_write_slot,
  output logic                               out_is_full
);

  import sma_pkg::*;

  logic signed [DATA_W-1:0] gain_r;
  logic signed [DATA_W-1:0] offset_r;
  logic [WIN_W-1:0]         window_r;
  logic                     cmd_valid;
  cmd_t                     cmd;
  logic                     cmd_pop;
  logic                     res_push;
  res_t                     res_in;
  logic                     res_full;
  logic [$bits(res_t)-1:0]  res_q;
  res_t                     res_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RST;
      offset_r <= OFFSET_RST;
      window_r <= WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_GAIN:   gain_r   <= cfg_wdata;
        CFG_OFFSET: offset_r <= cfg_wdata;
        CFG_WINDOW: window_r <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  sma_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (push),
    .in_full      (full),
    .in_kind      (in_kind),
    .in_sample    (in_sample),
    .in_position  (in_position),
    .in_look_past (in_look_past),
    .gain         (gain_r),
    .offset       (offset_r),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  sma_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .window_len (window_r),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .res_push   (res_push),
    .res        (res_in),
    .res_full   (res_full)
  );

  sma_fifo #(
    .WIDTH($bits(res_t))
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_q),
    .empty   (empty)
  );

  assign res_out            = res_t'(res_q);
  assign out_raw_value      = res_out.raw_value;
  assign out_filtered_value = res_out.filtered_value;
  assign out_write_slot     = res_out.write_slot;
  assign out_is_full        = res_out.is_full;

endmodule
